// ===== hw/rtl/nvmeqp_pkg.sv =====
// Shared types and constants for the NVMe host queue-pair engine.
package nvmeqp_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DB_STRIDE    = 2'd0;
  localparam logic [1:0] REG_SECTOR_SHIFT = 2'd1;
  localparam logic [1:0] REG_CTRL_READY   = 2'd2;

  localparam logic [3:0] SECTOR_SHIFT_RST = 4'd9;

  // Request operations
  localparam logic OP_SUBMIT   = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  localparam logic [7:0]  IO_OPC_WRITE = 8'd1;
  localparam logic [15:0] NVM_CMD_WRITE = 16'd1;
  localparam logic [15:0] NVM_CMD_READ  = 16'd2;

  localparam logic [18:0] DOORBELL_BASE = 19'h01000;

  typedef enum logic [1:0] {
    KIND_QUEUED    = 2'd0,
    KIND_CONSUMED  = 2'd1,
    KIND_NOT_READY = 2'd2,
    KIND_REJECTED  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot_index;
    logic [15:0] command_id;
    logic [31:0] dword0;
    logic [31:0] dword10;
    logic [31:0] dword11;
    logic [15:0] dword12;
    logic [18:0] doorbell_offset;
    logic [3:0]  doorbell_value;
    logic [10:0] status_code;
    logic        failed;
  } result_t;

endpackage

// ===== hw/rtl/nvme_host_queue_pair_engine.sv =====
// NVMe host queue-pair engine: admin and I/O submission/completion ring tracking.
// A request's result is captured in the output register on accept and is shown in the cycle after.
// Throughput: one request per cycle; the output register takes a new result in the
// same cycle its current one is taken, so input ready follows output ready.
// Reset (rst_n, synchronous): pointers 0, phases 1, next command id 1,
// registers to stride 0, sector shift 9, controller not ready; output empty.
module nvme_host_queue_pair_engine #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic                                in_queue,
  input  logic [7:0]                          in_opcode,
  input  logic [63:0]                         in_lba,
  input  logic [16:0]                         in_block_count,
  input  logic [31:0]                         in_cqe_dword3,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_kind,
  output logic [3:0]                          out_slot_index,
  output logic [15:0]                         out_command_id,
  output logic [31:0]                         out_dword0,
  output logic [31:0]                         out_dword10,
  output logic [31:0]                         out_dword11,
  output logic [15:0]                         out_dword12,
  output logic [18:0]                         out_doorbell_offset,
  output logic [3:0]                          out_doorbell_value,
  output logic [10:0]                         out_status_code,
  output logic                                out_failed,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nvmeqp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [nvmeqp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [nvmeqp_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready
);
  import nvmeqp_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [32:0] BUF_LIMIT = 33'(BUFFER_BYTES);

  // configuration registers
  logic [3:0] db_stride_r;
  logic [3:0] sector_shift_r;
  logic       ctrl_ready_r;

  // ring state
  logic [PTR_W-1:0] admin_tail_r, admin_head_r;
  logic [PTR_W-1:0] io_tail_r, io_head_r;
  logic             admin_phase_r, io_phase_r;
  logic [15:0]      cid_r;

  // output register
  logic    out_valid_r;
  result_t res_r;
  result_t res_nxt;

  logic cfg_wr;
  logic [1:0] cfg_idx;
  logic in_fire;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_stride_r    <= '0;
      sector_shift_r <= SECTOR_SHIFT_RST;
      ctrl_ready_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DB_STRIDE:    db_stride_r    <= pwdata[3:0];
        REG_SECTOR_SHIFT: sector_shift_r <= pwdata[3:0];
        REG_CTRL_READY:   ctrl_ready_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_DB_STRIDE:    prdata[3:0] = db_stride_r;
      REG_SECTOR_SHIFT: prdata[3:0] = sector_shift_r;
      REG_CTRL_READY:   prdata[0]   = ctrl_ready_r;
      default:          prdata      = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Per-request evaluation
  // ---------------------------------------------------------------------
  logic             is_submit, is_io;
  logic [PTR_W-1:0] tail_sel, head_sel, tail_inc, head_inc;
  logic             phase_sel, phase_ok;
  logic [32:0]      byte_cnt;
  logic             reject;
  logic [18:0]      stride;
  logic [19:0]      db_sum;
  logic [PTR_W+3:0] slot_ext, tail_ext, head_ext;
  logic [16:0]      cnt_m1;
  logic [15:0]      cmd_code;
  logic [10:0]      status;

  assign is_submit = (in_op == OP_SUBMIT);
  assign is_io     = in_queue;
  assign tail_sel  = is_io ? io_tail_r : admin_tail_r;
  assign head_sel  = is_io ? io_head_r : admin_head_r;
  assign phase_sel = is_io ? io_phase_r : admin_phase_r;
  assign tail_inc  = (tail_sel == PTR_LAST) ? '0 : tail_sel + 1'b1;
  assign head_inc  = (head_sel == PTR_LAST) ? '0 : head_sel + 1'b1;
  assign phase_ok  = (in_cqe_dword3[16] == phase_sel);

  assign byte_cnt = 33'(in_block_count) << sector_shift_r;
  assign reject   = is_io && (!ctrl_ready_r || (in_block_count == '0) ||
                              (byte_cnt > BUF_LIMIT));

  // doorbell index is 2*queue + completion
  assign stride = 19'd4 << db_stride_r;
  assign db_sum = 20'(DOORBELL_BASE)
                + (in_queue ? {stride, 1'b0} : 20'd0)
                + (in_op    ? 20'(stride)    : 20'd0);

  assign slot_ext = {4'b0, tail_sel};
  assign tail_ext = {4'b0, tail_inc};
  assign head_ext = {4'b0, head_inc};
  assign cnt_m1   = in_block_count - 17'd1;
  assign status   = in_cqe_dword3[27:17];
  assign cmd_code = !is_io ? 16'(in_opcode)
                  : ((in_opcode == IO_OPC_WRITE) ? NVM_CMD_WRITE : NVM_CMD_READ);

  always_comb begin
    res_nxt = '0;
    if (is_submit) begin
      if (reject) begin
        res_nxt.kind = KIND_REJECTED;
      end else begin
        res_nxt.kind            = KIND_QUEUED;
        res_nxt.slot_index      = slot_ext[3:0];
        res_nxt.command_id      = cid_r;
        res_nxt.dword0          = {cid_r, cmd_code};
        res_nxt.dword10         = in_lba[31:0];
        res_nxt.dword11         = in_lba[63:32];
        res_nxt.dword12         = is_io ? cnt_m1[15:0] : 16'd0;
        res_nxt.doorbell_offset = db_sum[18:0];
        res_nxt.doorbell_value  = tail_ext[3:0];
      end
    end else if (!phase_ok) begin
      res_nxt.kind = KIND_NOT_READY;
    end else begin
      res_nxt.kind            = KIND_CONSUMED;
      res_nxt.doorbell_offset = db_sum[18:0];
      res_nxt.doorbell_value  = head_ext[3:0];
      res_nxt.status_code     = status;
      res_nxt.failed          = (status != '0);
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  logic do_sub, do_cpl;
  assign do_sub = in_fire && is_submit && !reject;
  assign do_cpl = in_fire && !is_submit && phase_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      admin_tail_r  <= '0;
      admin_head_r  <= '0;
      io_tail_r     <= '0;
      io_head_r     <= '0;
      admin_phase_r <= 1'b1;
      io_phase_r    <= 1'b1;
      cid_r         <= 16'd1;
    end else begin
      if (do_sub) begin
        cid_r <= cid_r + 16'd1;
        if (is_io) io_tail_r <= tail_inc;
        else       admin_tail_r <= tail_inc;
      end
      if (do_cpl) begin
        // phase flips when the head wraps back to slot zero
        if (is_io) begin
          io_head_r <= head_inc;
          if (head_inc == '0) io_phase_r <= !io_phase_r;
        end else begin
          admin_head_r <= head_inc;
          if (head_inc == '0) admin_phase_r <= !admin_phase_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = res_r.kind;
  assign out_slot_index      = res_r.slot_index;
  assign out_command_id      = res_r.command_id;
  assign out_dword0          = res_r.dword0;
  assign out_dword10         = res_r.dword10;
  assign out_dword11         = res_r.dword11;
  assign out_dword12         = res_r.dword12;
  assign out_doorbell_offset = res_r.doorbell_offset;
  assign out_doorbell_value  = res_r.doorbell_value;
  assign out_status_code     = res_r.status_code;
  assign out_failed          = res_r.failed;

`ifndef SYNTHESIS
  a_cid_advance: assert property (@(posedge clk) disable iff (!rst_n)
    do_sub |=> (cid_r == $past(cid_r) + 16'd1))
    else $error("command id did not advance after queued submit");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (admin_tail_r <= PTR_LAST) && (admin_head_r <= PTR_LAST) &&
    (io_tail_r <= PTR_LAST) && (io_head_r <= PTR_LAST))
    else $error("ring pointer beyond queue depth");

  a_reject_no_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_submit && reject) |=>
      ($stable(cid_r) && $stable(io_tail_r) && $stable(admin_tail_r)))
    else $error("rejected submit changed queue state");

  a_fail_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_CONSUMED)) |-> (out_failed == (out_status_code != '0)))
    else $error("failed flag disagrees with status");
`endif

endmodule

// ===== tb/sv/nvme_host_queue_pair_engine_tb.sv =====
// Self-checking testbench for the NVMe host queue-pair engine.
`timescale 1ns / 1ps

module nvme_host_queue_pair_engine_tb;
  import nvmeqp_pkg::*;

  localparam int unsigned QP_DEPTH  = 16;
  localparam int unsigned BUF_BYTES = 4096;
  localparam int          LONG_HOLD_CYCLES = 300;

  localparam logic       QUEUE_ADMIN = 1'b0;
  localparam logic       QUEUE_IO    = 1'b1;
  localparam logic [7:0] IO_OPC_READ = 8'd2;

  typedef struct packed {
    logic        op;
    logic        queue;
    logic [7:0]  opcode;
    logic [63:0] lba;
    logic [16:0] block_count;
    logic [31:0] cqe_dword3;
  } qp_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = OP_SUBMIT;
  logic        in_queue = QUEUE_ADMIN;
  logic [7:0]  in_opcode = '0;
  logic [63:0] in_lba = '0;
  logic [16:0] in_block_count = '0;
  logic [31:0] in_cqe_dword3 = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [3:0]  out_slot_index;
  logic [15:0] out_command_id;
  logic [31:0] out_dword0;
  logic [31:0] out_dword10;
  logic [31:0] out_dword11;
  logic [15:0] out_dword12;
  logic [18:0] out_doorbell_offset;
  logic [3:0]  out_doorbell_value;
  logic [10:0] out_status_code;
  logic        out_failed;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  nvme_host_queue_pair_engine #(
    .QUEUE_DEPTH (QP_DEPTH),
    .BUFFER_BYTES(BUF_BYTES)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_queue           (in_queue),
    .in_opcode          (in_opcode),
    .in_lba             (in_lba),
    .in_block_count     (in_block_count),
    .in_cqe_dword3      (in_cqe_dword3),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_slot_index     (out_slot_index),
    .out_command_id     (out_command_id),
    .out_dword0         (out_dword0),
    .out_dword10        (out_dword10),
    .out_dword11        (out_dword11),
    .out_dword12        (out_dword12),
    .out_doorbell_offset(out_doorbell_offset),
    .out_doorbell_value (out_doorbell_value),
    .out_status_code    (out_status_code),
    .out_failed         (out_failed),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial forever #1 clk = ~clk;

  // run limit, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // register copies seen by the predictor
  logic [3:0] cfg_stride_exp = 4'd0;
  logic [3:0] cfg_sector_shift = SECTOR_SHIFT_RST;
  logic       cfg_ctrl_ready = 1'b0;

  // ring state mirrored from the block
  logic [3:0]  sq_tail [2] = '{4'd0, 4'd0};
  logic [3:0]  cq_head [2] = '{4'd0, 4'd0};
  logic        cq_phase [2] = '{1'b1, 1'b1};
  logic [15:0] pred_cmd_id = 16'd1;

  // stimulus-side view of the completion rings, to build entries with the right tag
  logic [3:0] gen_head [2] = '{4'd0, 4'd0};
  logic       gen_phase [2] = '{1'b1, 1'b1};

  qp_req_t pending_requests [$];
  result_t expected_results [$];
  qp_req_t cur_req;

  int  reqs_issued = 0;
  int  reqs_accepted = 0;
  int  mismatches = 0;
  bit  req_taken = 1'b0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;
  int  hold_left = 0;

  function automatic logic [18:0] doorbell_addr(input int unsigned db_index);
    return 19'(32'(DOORBELL_BASE) + db_index * (32'd4 << cfg_stride_exp));
  endfunction

  function automatic result_t predict_qp_result(input qp_req_t r);
    result_t        res;
    logic [15:0]    code;
    logic [15:0]    cid;
    longint unsigned span;
    res = '0;
    span = 64'(r.block_count) << cfg_sector_shift;
    if (r.op == OP_SUBMIT) begin
      if (r.queue == QUEUE_IO && (!cfg_ctrl_ready || r.block_count == 0 || span > BUF_BYTES))
      begin
        res.kind = KIND_REJECTED;
      end else begin
        if (r.queue == QUEUE_IO) begin
          code = (r.opcode == IO_OPC_WRITE) ? NVM_CMD_WRITE : NVM_CMD_READ;
          res.dword12 = 16'(r.block_count - 17'd1);
        end else begin
          code = {8'd0, r.opcode};
        end
        cid = pred_cmd_id;
        pred_cmd_id = pred_cmd_id + 16'd1;
        res.kind = KIND_QUEUED;
        res.slot_index = sq_tail[r.queue];
        res.command_id = cid;
        res.dword0 = {cid, code};
        res.dword10 = r.lba[31:0];
        res.dword11 = r.lba[63:32];
        // depth 16: the 4-bit pointer wraps by itself
        sq_tail[r.queue] = sq_tail[r.queue] + 4'd1;
        res.doorbell_offset = doorbell_addr(2 * int'(r.queue));
        res.doorbell_value = sq_tail[r.queue];
      end
    end else if (r.cqe_dword3[16] != cq_phase[r.queue]) begin
      res.kind = KIND_NOT_READY;
    end else begin
      cq_head[r.queue] = cq_head[r.queue] + 4'd1;
      if (cq_head[r.queue] == 4'd0) cq_phase[r.queue] = ~cq_phase[r.queue];
      res.kind = KIND_CONSUMED;
      res.doorbell_offset = doorbell_addr(2 * int'(r.queue) + 1);
      res.doorbell_value = cq_head[r.queue];
      res.status_code = r.cqe_dword3[27:17];
      res.failed = (r.cqe_dword3[27:17] != 11'd0);
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_op <= cur_req.op;
        in_queue <= cur_req.queue;
        in_opcode <= cur_req.opcode;
        in_lba <= cur_req.lba;
        in_block_count <= cur_req.block_count;
        in_cqe_dword3 <= cur_req.cqe_dword3;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver; one long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      hold_left = LONG_HOLD_CYCLES;
      long_hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // predict on accept, check on result
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_qp_result({in_op, in_queue, in_opcode, in_lba,
                                                      in_block_count, in_cqe_dword3}));
        reqs_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: kind 0x%0h", out_kind);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("slot_index", want.slot_index, out_slot_index);
          check_field("command_id", want.command_id, out_command_id);
          check_field("dword0", want.dword0, out_dword0);
          check_field("dword10", want.dword10, out_dword10);
          check_field("dword11", want.dword11, out_dword11);
          check_field("dword12", want.dword12, out_dword12);
          check_field("doorbell_offset", want.doorbell_offset, out_doorbell_offset);
          check_field("doorbell_value", want.doorbell_value, out_doorbell_value);
          check_field("status_code", want.status_code, out_status_code);
          check_field("failed", want.failed, out_failed);
        end
      end
    end
    req_taken <= rst_n && in_valid && in_ready;
  end

  task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      REG_DB_STRIDE:    cfg_stride_exp = value[3:0];
      REG_SECTOR_SHIFT: cfg_sector_shift = value[3:0];
      REG_CTRL_READY:   cfg_ctrl_ready = value[0];
      default: ;
    endcase
  endtask

  task automatic queue_item(input logic op, input logic q, input logic [7:0] opcode,
                            input logic [63:0] lba, input logic [16:0] count,
                            input logic [31:0] dw3);
    if (op == OP_COMPLETE && dw3[16] == gen_phase[q]) begin
      gen_head[q] = gen_head[q] + 4'd1;
      if (gen_head[q] == 4'd0) gen_phase[q] = ~gen_phase[q];
    end
    pending_requests.push_back({op, q, opcode, lba, count, dw3});
    reqs_issued++;
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (reqs_accepted != reqs_issued || expected_results.size() != 0);
  endtask

  task automatic add_random_requests(input int n, input bit admin_submits_only);
    logic        op;
    logic        q;
    logic [7:0]  opcode;
    logic [16:0] count;
    logic [31:0] dw3;
    int          sel;
    int          max_blocks;
    repeat (n) begin
      op = admin_submits_only ? OP_SUBMIT : logic'($urandom_range(1));
      q = admin_submits_only ? QUEUE_ADMIN : logic'($urandom_range(1));
      sel = $urandom_range(9);
      opcode = (sel < 3) ? IO_OPC_WRITE : (sel < 5) ? IO_OPC_READ : 8'($urandom);
      // zero when the block size exceeds the buffer
      max_blocks = BUF_BYTES >> cfg_sector_shift;
      sel = $urandom_range(9);
      if (sel < 7 && max_blocks > 0) count = 17'($urandom_range(max_blocks, 1));
      else if (sel == 7) count = 17'd0;
      else count = 17'($urandom);
      dw3 = $urandom;
      if ($urandom_range(99) < 85) dw3[16] = gen_phase[q];
      queue_item(op, q, opcode, {$urandom, $urandom}, count, dw3);
    end
  endtask

  task automatic run_phase(input logic [3:0] stride, input logic [3:0] shift,
                           input logic ready, input int send_idle, input int recv_stall,
                           input int n, input bit admin_submits_only, input bit long_hold);
    wait_quiet();
    cfg_write(REG_DB_STRIDE, 32'(stride));
    cfg_write(REG_SECTOR_SHIFT, 32'(shift));
    cfg_write(REG_CTRL_READY, 32'(ready));
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    if (long_hold) long_hold_req = 1'b1;
    add_random_requests(n, admin_submits_only);
    wait_quiet();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // controller not ready after reset: I/O rejected, admin still queued
    queue_item(OP_SUBMIT, QUEUE_IO, IO_OPC_WRITE, 64'd5, 17'd1, '0);
    queue_item(OP_SUBMIT, QUEUE_ADMIN, 8'hFF, '1, 17'd0, '1);
    queue_item(OP_SUBMIT, QUEUE_ADMIN, 8'h00, '0, 17'h1FFFF, '0);
    wait_quiet();
    cfg_write(REG_DB_STRIDE, 32'd15);
    cfg_write(REG_SECTOR_SHIFT, 32'd9);
    cfg_write(REG_CTRL_READY, 32'd1);
    queue_item(OP_SUBMIT, QUEUE_IO, IO_OPC_WRITE, 64'h0123_4567_89AB_CDEF, 17'd1, '0);
    queue_item(OP_SUBMIT, QUEUE_IO, IO_OPC_READ, '1, 17'd8, '0);  // exactly fills buffer
    queue_item(OP_SUBMIT, QUEUE_IO, 8'hFF, '0, 17'd9, '0);        // one block too many
    queue_item(OP_SUBMIT, QUEUE_IO, 8'h00, '0, 17'd0, '0);
    queue_item(OP_SUBMIT, QUEUE_IO, 8'h80, '1, 17'h1FFFF, '1);
    queue_item(OP_SUBMIT, QUEUE_IO, 8'h7F, 64'h8000_0000_0000_0001, 17'd2, '0);
    // completions: stale tag, max status, clean status
    queue_item(OP_COMPLETE, QUEUE_IO, '0, '0, '0, 32'h0000_0000);
    queue_item(OP_COMPLETE, QUEUE_IO, '1, '1, '1, 32'hFFFF_FFFF);
    queue_item(OP_COMPLETE, QUEUE_ADMIN, '0, '0, '0, 32'h0001_0000);
    queue_item(OP_COMPLETE, QUEUE_ADMIN, '0, '0, '0, 32'hFFFE_FFFF);
    queue_item(OP_COMPLETE, QUEUE_IO, '0, '0, '0, 32'h0003_0000);

    run_phase(4'd3, 4'd9, 1'b1, 0, 0, 240, 1'b0, 1'b0);
    run_phase(4'd15, 4'd12, 1'b1, 50, 0, 240, 1'b0, 1'b0);
    // receiver holds off long enough to back up the input
    run_phase(4'd0, 4'd0, 1'b1, 0, 50, 240, 1'b0, 1'b1);
    run_phase(4'd7, 4'd15, 1'b0, 14, 14, 200, 1'b0, 1'b0);
    run_phase(4'd1, 4'd10, 1'b1, 14, 14, 200, 1'b0, 1'b0);
    // short burst of admin submits back to back
    run_phase(4'd2, 4'd11, 1'b1, 0, 0, 16, 1'b1, 1'b0);

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
